>>> rtl/csh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csh_pkg
// Shared constants, types and helpers for the call stack hash coverage filter.
// ----------------------------------------------------------------------------
package csh_pkg;

   localparam int STACK_DEPTH     = 64;
   localparam int STACK_AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W           = $clog2(STACK_DEPTH + 1);
   localparam int COUNTER_ENTRIES = 65536;
   localparam int CTR_AW          = $clog2(COUNTER_ENTRIES);
   localparam int CTR_W           = 16;
   localparam int STRIDE_SHIFT    = 3;
   localparam int LEVEL_W         = 7;

   localparam logic [31:0] PR1 = 32'd2654435761;
   localparam logic [31:0] PR2 = 32'd2246822519;
   localparam logic [31:0] PR3 = 32'd3266489917;
   localparam logic [31:0] PR4 = 32'd668265263;
   localparam logic [31:0] PR5 = 32'd374761393;

   localparam logic [31:0] EMPTY_HASH = 32'h02CC5D05;

   typedef enum logic [1:0] {
      OP_CALL   = 2'd0,
      OP_RETURN = 2'd1,
      OP_BLOCK  = 2'd2,
      OP_UPDATE = 2'd3
   } item_op_type;

   typedef enum logic [2:0] {
      H_INIT_LONG  = 3'd0,
      H_INIT_SHORT = 3'd1,
      H_LANE       = 3'd2,
      H_MERGE      = 3'd3,
      H_TAIL       = 3'd4,
      H_FINAL      = 3'd5
   } hash_op_type;

   typedef struct packed {
      logic        start;
      hash_op_type op;
      logic [1:0]  lane;
      logic [31:0] word;
   } hash_cmd_type;

   typedef struct packed {
      logic        idle;
      logic [31:0] digest;
   } hash_stat_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
      return (v << r) | (v >> (32 - r));
   endfunction

endpackage

`default_nettype wire

>>> rtl/call_stack_hash_coverage_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// call_stack_hash_coverage_filter
// Call stack tracker with XXH32 context hash and hit-counter coverage filter.
// ----------------------------------------------------------------------------
// Call/return rehash all stack entries; a return first scans the stack from the top
//   down for its pc.
// Throughput: one word at a time; the shared multiplier of the hash engine sets it.
// Reset: synchronous; then a clearing pass over all COUNTER_ENTRIES (65536) hit
//   counters runs with req_tready low.
module call_stack_hash_coverage_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] pc
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [0] interesting, [1] push_dropped,
                                         // [8:2] stack_level, [15:9] zero
);
   typedef enum logic [17:0] {
      S_CLR     = 18'b000000000000000001,
      S_IDLE    = 18'b000000000000000010,
      S_RET_RD  = 18'b000000000000000100,
      S_RET_CMP = 18'b000000000000001000,
      S_RH_INIT = 18'b000000000000010000,
      S_RH_NEXT = 18'b000000000000100000,
      S_RH_LO   = 18'b000000000001000000,
      S_RH_HI   = 18'b000000000010000000,
      S_RH_MRG  = 18'b000000000100000000,
      S_RH_FIN  = 18'b000000001000000000,
      S_RH_END  = 18'b000000010000000000,
      S_UP_INIT = 18'b000000100000000000,
      S_UP_TAIL = 18'b000001000000000000,
      S_UP_FIN  = 18'b000010000000000000,
      S_UP_RD   = 18'b000100000000000000,
      S_UP_WR   = 18'b001000000000000000,
      S_RESP    = 18'b010000000000000000,
      S_SPARE   = 18'b100000000000000000
   } state_type;

   localparam int CW = csh_pkg::CNT_W;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                j_ff, j_in;
   logic                         merged_ff, merged_in;
   logic [31:0]                  shash_ff, shash_in;
   logic [63:0]                  bpc_ff, bpc_in;
   logic                         pend_ff, pend_in;
   logic                         intr_ff, intr_in;
   logic                         drop_ff, drop_in;
   logic [63:0]                  pc_ff, pc_in;
   logic [csh_pkg::CTR_AW-1:0]   clr_ff, clr_in;
   logic                         ovld_ff, ovld_in;
   logic [15:0]                  odata_ff, odata_in;

   csh_pkg::hash_cmd_type        hcmd;
   csh_pkg::hash_stat_type       hstat;

   logic                         st_we, st_re;
   logic [csh_pkg::STACK_AW-1:0] st_addr;
   logic [63:0]                  st_rdata;
   logic                         ct_we, ct_re;
   logic [csh_pkg::CTR_AW-1:0]   ct_addr;
   logic [csh_pkg::CTR_W-1:0]    ct_wdata, ct_rdata, q;

   logic                         accept;
   logic [CW-1:0]                even_cnt;
   logic                         is_long;
   logic                         in_pairs;
   logic [31:0]                  len_bytes;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign even_cnt   = {count_ff[CW-1:1], 1'b0};
   assign is_long    = (count_ff >= CW'(2));
   assign in_pairs   = (j_ff < even_cnt);
   assign len_bytes  = 32'(count_ff) << 3;
   assign q          = ct_rdata >> csh_pkg::STRIDE_SHIFT;

   csh_xxh u_xxh (
      .clock (clock),
      .reset (reset),
      .cmd   (hcmd),
      .stat  (hstat)
   );

   csh_ram #(
      .WIDTH (64),
      .DEPTH (csh_pkg::STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (st_we),
      .re    (st_re),
      .addr  (st_addr),
      .wdata (req_tdata),
      .rdata (st_rdata)
   );

   csh_ram #(
      .WIDTH (csh_pkg::CTR_W),
      .DEPTH (csh_pkg::COUNTER_ENTRIES)
   ) u_ctr (
      .clock (clock),
      .we    (ct_we),
      .re    (ct_re),
      .addr  (ct_addr),
      .wdata (ct_wdata),
      .rdata (ct_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      merged_in = merged_ff;
      shash_in  = shash_ff;
      bpc_in    = bpc_ff;
      pend_in   = pend_ff;
      intr_in   = intr_ff;
      drop_in   = drop_ff;
      pc_in     = pc_ff;
      clr_in    = clr_ff;
      ovld_in   = ovld_ff;
      odata_in  = odata_ff;
      hcmd      = '{start: 1'b0, op: csh_pkg::H_INIT_SHORT, lane: 2'd0, word: 32'd0};
      st_we     = 1'b0;
      st_re     = 1'b0;
      st_addr   = j_ff[csh_pkg::STACK_AW-1:0];
      ct_we     = 1'b0;
      ct_re     = 1'b0;
      ct_addr   = hstat.digest[csh_pkg::CTR_AW-1:0];
      ct_wdata  = ct_rdata + csh_pkg::CTR_W'(1);

      if (rsp_tvalid && rsp_tready) begin
         ovld_in = 1'b0;
      end

      unique case (state_ff)
         S_CLR: begin
            ct_we    = 1'b1;
            ct_addr  = clr_ff;
            ct_wdata = '0;
            clr_in   = clr_ff + csh_pkg::CTR_AW'(1);
            if (clr_ff == csh_pkg::CTR_AW'(csh_pkg::COUNTER_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               drop_in = 1'b0;
               pc_in   = req_tdata;
               case (csh_pkg::item_op_type'(req_tuser))
                  csh_pkg::OP_CALL: begin
                     if (count_ff >= CW'(csh_pkg::STACK_DEPTH)) begin
                        drop_in  = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        st_we    = 1'b1;
                        st_addr  = count_ff[csh_pkg::STACK_AW-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = S_RH_INIT;
                     end
                  end
                  csh_pkg::OP_RETURN: begin
                     if (count_ff == '0) begin
                        state_in = S_RH_INIT;
                     end else begin
                        j_in     = count_ff - CW'(1);
                        state_in = S_RET_RD;
                     end
                  end
                  csh_pkg::OP_BLOCK: begin
                     bpc_in   = req_tdata;
                     pend_in  = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     if (pend_ff) begin
                        pend_in  = 1'b0;
                        state_in = S_UP_INIT;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
               endcase
            end
         end
         S_RET_RD: begin
            st_re    = 1'b1;
            state_in = S_RET_CMP;
         end
         S_RET_CMP: begin
            if (st_rdata == pc_ff) begin
               count_in = j_ff;
               state_in = S_RH_INIT;
            end else if (j_ff == '0) begin
               count_in = '0;
               state_in = S_RH_INIT;
            end else begin
               j_in     = j_ff - CW'(1);
               state_in = S_RET_RD;
            end
         end
         S_RH_INIT: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = is_long ? csh_pkg::H_INIT_LONG : csh_pkg::H_INIT_SHORT;
               hcmd.word  = len_bytes;
               j_in       = '0;
               merged_in  = 1'b0;
               state_in   = S_RH_NEXT;
            end
         end
         S_RH_NEXT: begin
            if (in_pairs) begin
               st_re    = 1'b1;
               state_in = S_RH_LO;
            end else if (is_long && !merged_ff) begin
               state_in = S_RH_MRG;
            end else if (j_ff < count_ff) begin
               st_re    = 1'b1;
               state_in = S_RH_LO;
            end else begin
               state_in = S_RH_FIN;
            end
         end
         S_RH_LO: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = in_pairs ? csh_pkg::H_LANE : csh_pkg::H_TAIL;
               hcmd.lane  = {j_ff[0], 1'b0};
               hcmd.word  = st_rdata[31:0];
               state_in   = S_RH_HI;
            end
         end
         S_RH_HI: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = in_pairs ? csh_pkg::H_LANE : csh_pkg::H_TAIL;
               hcmd.lane  = {j_ff[0], 1'b1};
               hcmd.word  = st_rdata[63:32];
               j_in       = j_ff + CW'(1);
               state_in   = S_RH_NEXT;
            end
         end
         S_RH_MRG: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = csh_pkg::H_MERGE;
               hcmd.word  = len_bytes;
               merged_in  = 1'b1;
               state_in   = S_RH_NEXT;
            end
         end
         S_RH_FIN: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = csh_pkg::H_FINAL;
               state_in   = S_RH_END;
            end
         end
         S_RH_END: begin
            if (hstat.idle) begin
               shash_in = hstat.digest;
               state_in = S_RESP;
            end
         end
         S_UP_INIT: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = csh_pkg::H_INIT_SHORT;
               hcmd.word  = 32'd12;
               j_in       = '0;
               state_in   = S_UP_TAIL;
            end
         end
         S_UP_TAIL: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = csh_pkg::H_TAIL;
               case (j_ff[1:0])
                  2'd0:    hcmd.word = bpc_ff[31:0];
                  2'd1:    hcmd.word = bpc_ff[63:32];
                  default: hcmd.word = shash_ff;
               endcase
               j_in = j_ff + CW'(1);
               if (j_ff[1:0] == 2'd2) begin
                  state_in = S_UP_FIN;
               end
            end
         end
         S_UP_FIN: begin
            if (hstat.idle) begin
               hcmd.start = 1'b1;
               hcmd.op    = csh_pkg::H_FINAL;
               state_in   = S_UP_RD;
            end
         end
         S_UP_RD: begin
            if (hstat.idle) begin
               ct_re    = 1'b1;
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            ct_we    = 1'b1;
            intr_in  = ((q & (q - csh_pkg::CTR_W'(1))) == '0);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!ovld_ff || rsp_tready) begin
               ovld_in  = 1'b1;
               odata_in = {7'd0, csh_pkg::LEVEL_W'(count_ff), drop_ff, intr_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         count_ff <= '0;
         shash_ff <= csh_pkg::EMPTY_HASH;
         bpc_ff   <= '0;
         pend_ff  <= 1'b0;
         intr_ff  <= 1'b1;
         drop_ff  <= 1'b0;
         clr_ff   <= '0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         shash_ff <= shash_in;
         bpc_ff   <= bpc_in;
         pend_ff  <= pend_in;
         intr_ff  <= intr_in;
         drop_ff  <= drop_in;
         clr_ff   <= clr_in;
         ovld_ff  <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      merged_ff <= merged_in;
      pc_ff     <= pc_in;
      odata_ff  <= odata_in;
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;

endmodule

`default_nettype wire

>>> rtl/csh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csh_ram
// Single-port RAM, registered read with read enable.
// ----------------------------------------------------------------------------
module csh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic                                         re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                             wdata,
   output logic      [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/csh_xxh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csh_xxh
// XXH32 step engine around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module csh_xxh (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csh_pkg::hash_cmd_type cmd,
   output csh_pkg::hash_stat_type     stat
);
   typedef enum logic [9:0] {
      X_IDLE = 10'b0000000001,
      X_EXEC = 10'b0000000010,
      X_MIN  = 10'b0000000100,
      X_ROT  = 10'b0000001000,
      X_MOUT = 10'b0000010000,
      X_F1   = 10'b0000100000,
      X_F2   = 10'b0001000000,
      X_F3   = 10'b0010000000,
      X_F4   = 10'b0100000000,
      X_F5   = 10'b1000000000
   } xstate_type;

   xstate_type            state_ff, state_in;
   csh_pkg::hash_cmd_type cmd_ff;
   logic [31:0]           v_ff [4];
   logic [31:0]           h_ff;
   logic [31:0]           prod_ff;
   logic [31:0]           tmp_ff;
   logic [31:0]           mul_a, mul_b;
   logic [63:0]           mul_full;
   logic [31:0]           acc;
   logic                  is_lane;

   assign is_lane  = (cmd_ff.op == csh_pkg::H_LANE);
   assign acc      = is_lane ? v_ff[cmd_ff.lane] : h_ff;
   assign mul_full = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         X_MIN: begin
            mul_a = cmd_ff.word;
            mul_b = is_lane ? csh_pkg::PR2 : csh_pkg::PR3;
         end
         X_MOUT: begin
            mul_a = tmp_ff;
            mul_b = is_lane ? csh_pkg::PR1 : csh_pkg::PR4;
         end
         X_F2: begin
            mul_a = h_ff;
            mul_b = csh_pkg::PR2;
         end
         X_F4: begin
            mul_a = h_ff;
            mul_b = csh_pkg::PR3;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         X_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  csh_pkg::H_LANE, csh_pkg::H_TAIL: state_in = X_MIN;
                  csh_pkg::H_FINAL:                 state_in = X_F1;
                  default:                          state_in = X_EXEC;
               endcase
            end
         end
         X_EXEC: state_in = X_IDLE;
         X_MIN:  state_in = X_ROT;
         X_ROT:  state_in = X_MOUT;
         X_MOUT: state_in = X_IDLE;
         X_F1:   state_in = X_F2;
         X_F2:   state_in = X_F3;
         X_F3:   state_in = X_F4;
         X_F4:   state_in = X_F5;
         X_F5:   state_in = X_IDLE;
         default: state_in = X_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= X_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         X_IDLE: begin
            if (cmd.start) begin
               cmd_ff <= cmd;
            end
         end
         X_EXEC: begin
            unique case (cmd_ff.op)
               csh_pkg::H_INIT_LONG: begin
                  v_ff[0] <= csh_pkg::PR1 + csh_pkg::PR2;
                  v_ff[1] <= csh_pkg::PR2;
                  v_ff[2] <= '0;
                  v_ff[3] <= 32'd0 - csh_pkg::PR1;
               end
               csh_pkg::H_INIT_SHORT: h_ff <= csh_pkg::PR5 + cmd_ff.word;
               csh_pkg::H_MERGE: begin
                  h_ff <= csh_pkg::rotl32(v_ff[0], 1) + csh_pkg::rotl32(v_ff[1], 7)
                        + csh_pkg::rotl32(v_ff[2], 12) + csh_pkg::rotl32(v_ff[3], 18)
                        + cmd_ff.word;
               end
               default: begin
               end
            endcase
         end
         X_MIN: prod_ff <= mul_full[31:0];
         X_ROT: tmp_ff <= is_lane ? csh_pkg::rotl32(acc + prod_ff, 13)
                                  : csh_pkg::rotl32(acc + prod_ff, 17);
         X_MOUT: begin
            if (is_lane) begin
               v_ff[cmd_ff.lane] <= mul_full[31:0];
            end else begin
               h_ff <= mul_full[31:0];
            end
         end
         X_F1: h_ff <= h_ff ^ (h_ff >> 15);
         X_F2: h_ff <= mul_full[31:0];
         X_F3: h_ff <= h_ff ^ (h_ff >> 13);
         X_F4: h_ff <= mul_full[31:0];
         X_F5: h_ff <= h_ff ^ (h_ff >> 16);
         default: begin
         end
      endcase
   end

   assign stat.idle   = (state_ff == X_IDLE);
   assign stat.digest = h_ff;

endmodule

`default_nettype wire

>>> rtl/csh_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csh_chk
// Port-level checks for the call stack hash coverage filter.
// ----------------------------------------------------------------------------
module csh_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   localparam logic [6:0] FULL = 7'(csh_pkg::STACK_DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted again while busy");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:2] <= FULL)
      else $error("stack level beyond depth");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[8:2] == FULL)
      else $error("push dropped with stack not full");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0)
      else $error("rsp padding not zero");

endmodule

bind call_stack_hash_coverage_filter csh_chk u_csh_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
